@@ design/sdrr_pkg.sv @@
// Shared types and constants for the SD SPI-mode response receiver.
package sdrr_pkg;

   localparam int LENGTH_W             = 12;
   localparam int LENGTH_CAP_LIMIT     = 4095;
   localparam int DEF_MAX_LENGTH       = 2048;
   localparam int DEF_TOKEN_POLL_LIMIT = 1500;

   localparam int RESP_POLLS  = 9;
   localparam int REG_POLLS   = 8;
   localparam int DRESP_POLLS = 18;

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] START_TOKEN = 8'hFE;
   localparam logic [7:0] DRESP_MASK  = 8'h1F;
   localparam logic [7:0] DRESP_OK    = 8'h05;
   localparam logic [1:0] CRC_BYTES   = 2'd2;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_BYTE  = 1'b1
   } sdrr_action_type;

   typedef enum logic [1:0] {
      MODE_CMD_RESP = 2'd0,
      MODE_REG_READ = 2'd1,
      MODE_BLOCK    = 2'd2,
      MODE_DRESP    = 2'd3
   } sdrr_mode_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_WAIT_RESP  = 3'd1,
      PH_WAIT_REG   = 3'd2,
      PH_PAYLOAD    = 3'd3,
      PH_WAIT_TOKEN = 3'd4,
      PH_BLOCK      = 3'd5,
      PH_CRC        = 3'd6,
      PH_WAIT_DRESP = 3'd7
   } sdrr_phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       done_res;
      logic       status;
   } sdrr_result_type;

endpackage

@@ design/sdrr_req_if.sv @@
// Request channel interface: start items and received MISO bytes.
interface sdrr_req_if;
   import sdrr_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [1:0]          mode;
   logic [LENGTH_W-1:0] length;
   logic [7:0]          rx_byte;

   modport source (output valid, action, mode, length, rx_byte, input ready);
   modport sink   (input valid, action, mode, length, rx_byte, output ready);
endinterface

@@ design/sdrr_rsp_if.sv @@
// Response channel interface: kept bytes and transaction completion.
interface sdrr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       done_res;
   logic       status;

   modport source (output valid, out_byte, is_data, done_res, status, input ready);
   modport sink   (input valid, out_byte, is_data, done_res, status, output ready);
endinterface

@@ design/sdrr_step.sv @@
// Per-item next-state and result logic of the response receiver.
module sdrr_step #(
   parameter int CAP              = sdrr_pkg::DEF_MAX_LENGTH,
   parameter int TOKEN_POLL_LIMIT = sdrr_pkg::DEF_TOKEN_POLL_LIMIT,
   parameter int BL_W             = 12,
   parameter int PC_W             = 11
) (
   input  logic                          action,
   input  logic [1:0]                    mode,
   input  logic [sdrr_pkg::LENGTH_W-1:0] length,
   input  logic [7:0]                    rx_byte,
   input  sdrr_pkg::sdrr_phase_type      phase,
   input  sdrr_pkg::sdrr_mode_type       active_mode,
   input  logic [BL_W-1:0]               bytes_left,
   input  logic [PC_W-1:0]               poll_count,
   input  logic [1:0]                    crc_left,
   output sdrr_pkg::sdrr_phase_type      phase_in,
   output sdrr_pkg::sdrr_mode_type       active_mode_in,
   output logic [BL_W-1:0]               bytes_left_in,
   output logic [PC_W-1:0]               poll_count_in,
   output logic [1:0]                    crc_left_in,
   output logic                          emit,
   output sdrr_pkg::sdrr_result_type     result
);
   import sdrr_pkg::*;

   logic [BL_W-1:0] bl_dec;
   logic [BL_W-1:0] bl_block;
   logic [PC_W-1:0] poll_inc;
   logic [1:0]      crc_dec;
   logic [BL_W-1:0] start_len;
   logic            is_fill;
   logic            is_token;
   logic            is_dresp;
   logic            bl_last;

   assign bl_dec   = bytes_left - BL_W'(1);
   assign bl_last  = (bl_dec == '0);
   assign bl_block = {bytes_left[BL_W-1:2], 2'b00};
   assign poll_inc = poll_count + PC_W'(1);
   assign crc_dec  = crc_left - 2'd1;
   assign is_fill  = (rx_byte == FILL_BYTE);
   assign is_token = (rx_byte == START_TOKEN);
   assign is_dresp = ((rx_byte & DRESP_MASK) == DRESP_OK);

   // zero length counts as one, long lengths saturate
   always_comb begin
      if (length == '0) begin
         start_len = BL_W'(1);
      end else if (length > LENGTH_W'(CAP)) begin
         start_len = BL_W'(CAP);
      end else begin
         start_len = BL_W'(length);
      end
   end

   // next phase
   always_comb begin
      phase_in = phase;
      if (action == ACT_START) begin
         unique case (sdrr_mode_type'(mode))
            MODE_BLOCK: phase_in = PH_WAIT_TOKEN;
            MODE_DRESP: phase_in = PH_WAIT_DRESP;
            default:    phase_in = PH_WAIT_RESP;
         endcase
      end else begin
         unique case (phase)
            PH_IDLE: phase_in = PH_IDLE;
            PH_WAIT_RESP: begin
               if (!is_fill) begin
                  if (bl_last) begin
                     phase_in = PH_IDLE;
                  end else if (active_mode == MODE_REG_READ) begin
                     phase_in = PH_WAIT_REG;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else if (poll_inc >= PC_W'(RESP_POLLS)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_WAIT_REG: begin
               if (!is_fill) begin
                  phase_in = bl_last ? PH_IDLE : PH_PAYLOAD;
               end else if (poll_inc >= PC_W'(REG_POLLS)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PAYLOAD: begin
               if (bl_last) phase_in = PH_IDLE;
            end
            PH_WAIT_TOKEN: begin
               if (is_token) begin
                  phase_in = (bl_block == '0) ? PH_CRC : PH_BLOCK;
               end else if (poll_inc >= PC_W'(TOKEN_POLL_LIMIT)) begin
                  phase_in = PH_IDLE;
               end
            end
            PH_BLOCK: begin
               if (bl_last) phase_in = PH_CRC;
            end
            PH_CRC: begin
               if (crc_dec == 2'd0) phase_in = PH_IDLE;
            end
            PH_WAIT_DRESP: begin
               if (is_dresp || poll_inc >= PC_W'(DRESP_POLLS)) phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // counters and result
   always_comb begin
      active_mode_in = active_mode;
      bytes_left_in  = bytes_left;
      poll_count_in  = poll_count;
      crc_left_in    = crc_left;
      emit           = 1'b0;
      result         = '{out_byte: rx_byte, is_data: 1'b0, done_res: 1'b0, status: 1'b0};
      if (action == ACT_START) begin
         active_mode_in = sdrr_mode_type'(mode);
         bytes_left_in  = start_len;
         poll_count_in  = '0;
         crc_left_in    = 2'd0;
      end else begin
         unique case (phase)
            PH_IDLE: emit = 1'b0;
            PH_WAIT_RESP, PH_WAIT_REG: begin
               poll_count_in = poll_inc;
               if (!is_fill) begin
                  bytes_left_in   = bl_dec;
                  emit            = 1'b1;
                  result.is_data  = 1'b1;
                  result.done_res = bl_last;
                  if (!bl_last) poll_count_in = '0;
               end else if (poll_inc >= PC_W'((phase == PH_WAIT_RESP) ? RESP_POLLS
                                                                      : REG_POLLS)) begin
                  emit            = 1'b1;
                  result.done_res = 1'b1;
                  result.status   = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               bytes_left_in   = bl_dec;
               emit            = 1'b1;
               result.is_data  = 1'b1;
               result.done_res = bl_last;
               if (!bl_last) poll_count_in = '0;
            end
            PH_WAIT_TOKEN: begin
               poll_count_in = poll_inc;
               if (is_token) begin
                  bytes_left_in = bl_block;
                  crc_left_in   = CRC_BYTES;
               end else if (poll_inc >= PC_W'(TOKEN_POLL_LIMIT)) begin
                  emit            = 1'b1;
                  result.done_res = 1'b1;
                  result.status   = 1'b1;
               end
            end
            PH_BLOCK: begin
               bytes_left_in  = bl_dec;
               emit           = 1'b1;
               result.is_data = 1'b1;
               if (bl_last) crc_left_in = CRC_BYTES;
            end
            PH_CRC: begin
               crc_left_in = crc_dec;
               if (crc_dec == 2'd0) begin
                  emit            = 1'b1;
                  result.done_res = 1'b1;
               end
            end
            PH_WAIT_DRESP: begin
               poll_count_in = poll_inc;
               if (is_dresp) begin
                  emit            = 1'b1;
                  result.is_data  = 1'b1;
                  result.done_res = 1'b1;
               end else if (poll_inc >= PC_W'(DRESP_POLLS)) begin
                  emit            = 1'b1;
                  result.done_res = 1'b1;
                  result.status   = 1'b1;
               end
            end
            default: emit = 1'b0;
         endcase
      end
   end
endmodule

@@ design/sd_spi_response_receiver_unit.sv @@
// Top level of the SD SPI-mode response receiver.
//
// Usage:
//  - req_chan carries one transaction per item. action = start loads a
//    mode (command response, register read, data block read, data
//    response) and the expected reply length; action = byte delivers one
//    byte read from MISO. A start while busy drops the running reply.
//  - rsp_chan carries zero or one result per request: kept response and
//    payload bytes (is_data = 1), and a final result with done_res = 1 and
//    status (1 = timeout waiting for the response, token or data response).
//  - Wait-phase fill bytes short of a timeout, the start token and the first CRC byte emit nothing.
//  - Latency: a result shows on rsp_chan the cycle after its request is
//    accepted. Throughput: one request per cycle unless stalled; the per-byte state
//    update is a single pass of small compare and decrement logic.
//  - Stall: the result register holds while rsp_chan.ready is low, and
//    req_chan.ready drops only while a result waits and is not being taken.
//  - Reset (synchronous, active high) returns to idle with an empty result
//    register; bytes that arrive while idle are dropped.
module sd_spi_response_receiver_unit #(
   parameter int MAX_LENGTH       = sdrr_pkg::DEF_MAX_LENGTH,
   parameter int TOKEN_POLL_LIMIT = sdrr_pkg::DEF_TOKEN_POLL_LIMIT
) (
   input logic       clock,
   input logic       reset,
   sdrr_req_if.sink  req_chan,
   sdrr_rsp_if.source rsp_chan
);
   import sdrr_pkg::*;

   localparam int CAP      = (MAX_LENGTH > LENGTH_CAP_LIMIT) ? LENGTH_CAP_LIMIT : MAX_LENGTH;
   localparam int BL_W     = $clog2(CAP + 1);
   localparam int POLL_MAX = (TOKEN_POLL_LIMIT > DRESP_POLLS) ? TOKEN_POLL_LIMIT : DRESP_POLLS;
   localparam int PC_W     = $clog2(POLL_MAX + 1);

   sdrr_phase_type  phase_ff, phase_in;
   sdrr_mode_type   mode_ff, mode_in;
   logic [BL_W-1:0] bytes_left_ff, bytes_left_in;
   logic [PC_W-1:0] poll_ff, poll_in;
   logic [1:0]      crc_ff, crc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   sdrr_result_type result_ff, result_in;
   logic            emit;
   logic            req_ready;
   logic            accept;

   // a waiting result blocks new requests only while it is not being taken
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   sdrr_step #(
      .CAP              (CAP),
      .TOKEN_POLL_LIMIT (TOKEN_POLL_LIMIT),
      .BL_W             (BL_W),
      .PC_W             (PC_W)
   ) u_step (
      .action         (req_chan.action),
      .mode           (req_chan.mode),
      .length         (req_chan.length),
      .rx_byte        (req_chan.rx_byte),
      .phase          (phase_ff),
      .active_mode    (mode_ff),
      .bytes_left     (bytes_left_ff),
      .poll_count     (poll_ff),
      .crc_left       (crc_ff),
      .phase_in       (phase_in),
      .active_mode_in (mode_in),
      .bytes_left_in  (bytes_left_in),
      .poll_count_in  (poll_in),
      .crc_left_in    (crc_in),
      .emit           (emit),
      .result         (result_in)
   );

   // output register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) rsp_valid_in = 1'b0;
      if (accept && emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         mode_ff       <= MODE_CMD_RESP;
         bytes_left_ff <= '0;
         poll_ff       <= '0;
         crc_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff      <= phase_in;
            mode_ff       <= mode_in;
            bytes_left_ff <= bytes_left_in;
            poll_ff       <= poll_in;
            crc_ff        <= crc_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && emit) result_ff <= result_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = result_ff.out_byte;
   assign rsp_chan.is_data  = result_ff.is_data;
   assign rsp_chan.done_res = result_ff.done_res;
   assign rsp_chan.status   = result_ff.status;

   // a start always leaves the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.action == ACT_START |=> phase_ff != PH_IDLE)
      else $error("start transaction did not leave idle");

   // a final result always returns the block to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      accept && emit && result_in.done_res |=> phase_ff == PH_IDLE)
      else $error("final result did not return to idle");

   // a timeout is always final and never carries data
   a_timeout_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status |-> result_ff.done_res && !result_ff.is_data)
      else $error("timeout result not final or marked as data");

   // CRC phase never runs with an exhausted CRC count
   a_crc_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_CRC |-> crc_ff != 2'd0)
      else $error("CRC phase with zero CRC bytes left");

   // no result is produced from idle
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_IDLE && req_chan.action == ACT_BYTE |=> !rsp_valid_ff
         || $past(rsp_valid_ff && !rsp_chan.ready) || !$past(rsp_chan.ready) && $past(rsp_valid_ff))
      else $error("result produced while idle");
endmodule
